// File: rtl/core/efws_pkg.sv
// efws_pkg: shared sizes, constants and controller/datapath signal groups
// for the earliest-free-worker scheduler; no dependencies
package efws_pkg;

  // heap size and derived index widths
  localparam int MAX_WORKERS = 256;
  localparam int IDX_W       = $clog2(MAX_WORKERS);
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int CHILD_W     = IDX_W + 2;

  // field widths
  localparam int TIME_W = 63;
  localparam int DUR_W  = 32;
  localparam int CFG_W  = 9;
  localparam int WIDX_W = 8;
  localparam int KEY_W  = TIME_W + IDX_W;
  localparam int OUT_W  = ((WIDX_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - WIDX_W - TIME_W;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;  // config beat: new worker count, all workers free
    logic load;   // input beat: emit root, start sifting from the root
    logic fetch;  // read both children of the current position
    logic swap;   // move the earlier child up, descend
    logic place;  // drop the sifted entry at the current position
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;    // result register empty or drained this cycle
    logic has_left;    // current position has a left child in use
    logic child_wins;  // earlier child comes before the sifted entry
  } sts_t;

endpackage

// File: rtl/core/earliest_free_worker_scheduler.sv
// earliest_free_worker_scheduler: top level, streaming ports and config channel
// depends on efws_pkg, efws_ctrl, efws_datapath
//
// Each input beat carries one task duration; the task goes to the worker that
// becomes free earliest (lower worker number on equal times) and one output
// beat returns that worker and its start time. Finish times saturate at
// 2^63-1. The heap root sits in registers, so the result is known at the input
// beat; the root is then sifted down through a heap memory with two read ports,
// one level at a time (read both children, then compare and write back); the
// sift ends at a leaf or when the compare keeps the sifted entry in place. A new
// input beat is taken once the sift is done, no config write is pending and the
// result register is free or being drained. Writing worker_count (clamped to
// 1..256) makes every worker free at time 0.
module earliest_free_worker_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  // config: worker_count
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efws_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [efws_pkg::DUR_W-1:0]       s_axis_tdata,  // [31:0] task_duration
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [efws_pkg::OUT_W-1:0]       m_axis_tdata   // [7:0] worker_index,
                                                          // [70:8] start time
);

  efws_pkg::cmd_t                cmd;
  efws_pkg::sts_t                sts;
  logic [efws_pkg::WIDX_W-1:0]   worker_index;
  logic [efws_pkg::TIME_W-1:0]   task_start;

  efws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  efws_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_data      (cfg_data),
    .task_duration (s_axis_tdata),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .worker_index  (worker_index),
    .task_start    (task_start)
  );

  // pack the result beat, lowest field first
  assign m_axis_tdata = {{efws_pkg::OUT_PAD{1'b0}}, task_start, worker_index};

endmodule

// File: rtl/core/efws_ctrl.sv
// efws_ctrl: sequencer for the heap sift-down, one level per read/compare pair
// depends on efws_pkg
module efws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  efws_pkg::sts_t    sts,
  output efws_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   idle;

  assign idle          = (state == S_IDLE);
  assign cfg_ready     = idle;
  assign s_axis_tready = idle && !cfg_valid && sts.out_free;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.clear = cfg_valid;
        cmd.load  = s_axis_tvalid && s_axis_tready;
        if (cmd.load) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.has_left) begin
          cmd.fetch  = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CMP: begin
        if (sts.child_wins) begin
          cmd.swap   = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/efws_datapath.sv
// efws_datapath: heap memory with per-entry valid bits, root and sift registers,
// saturating finish-time add and result register; depends on efws_pkg
module efws_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  efws_pkg::cmd_t                   cmd,
  output efws_pkg::sts_t                   sts,
  input  logic [efws_pkg::CFG_W-1:0]       cfg_data,
  input  logic [efws_pkg::DUR_W-1:0]       task_duration,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [efws_pkg::WIDX_W-1:0]      worker_index,
  output logic [efws_pkg::TIME_W-1:0]      task_start
);

  localparam int IDX_W   = efws_pkg::IDX_W;
  localparam int CNT_W   = efws_pkg::CNT_W;
  localparam int CHILD_W = efws_pkg::CHILD_W;
  localparam int TIME_W  = efws_pkg::TIME_W;
  localparam int KEY_W   = efws_pkg::KEY_W;
  localparam int MAXW    = efws_pkg::MAX_WORKERS;

  // heap entries below the root; key is {finish time, worker id}
  logic [KEY_W-1:0]   mem_key [MAXW];
  logic [MAXW-1:0]    mem_ok;

  logic [KEY_W-1:0]   root_key;
  logic [KEY_W-1:0]   item_key;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic [KEY_W-1:0]   rd_l_key;
  logic [KEY_W-1:0]   rd_r_key;
  logic [IDX_W-1:0]   rd_l_addr;
  logic [IDX_W-1:0]   rd_r_addr;
  logic               rd_l_ok;
  logic               rd_r_ok;
  logic               r_in_use;

  logic [CHILD_W-1:0] left_idx;
  logic [CHILD_W-1:0] right_idx;
  logic [KEY_W-1:0]   l_key;
  logic [KEY_W-1:0]   r_key;
  logic               r_before_l;
  logic [KEY_W-1:0]   best_key;
  logic [CHILD_W-1:0] best_idx;

  logic [TIME_W:0]    fin_sum;
  logic [TIME_W-1:0]  fin_sat;
  logic               wr_en;
  logic [KEY_W-1:0]   wr_key;
  logic [31:0]        cfg_val;

  // child positions of the current sift position
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + CHILD_W'(1);

  // entries never written since the last clear read as free, worker = position
  assign l_key = rd_l_ok ? rd_l_key : {TIME_W'(0), rd_l_addr};
  assign r_key = rd_r_ok ? rd_r_key : {TIME_W'(0), rd_r_addr};

  // pick the earlier child, ties on time broken by lower worker id
  assign r_before_l = r_in_use && (r_key < l_key);
  assign best_key   = r_before_l ? r_key : l_key;
  assign best_idx   = r_before_l ? right_idx : left_idx;

  assign sts.has_left   = left_idx < CHILD_W'(count);
  assign sts.child_wins = best_key < item_key;
  assign sts.out_free   = !m_tvalid || m_tready;

  // saturating finish time of the new task
  assign fin_sum = {1'b0, root_key[KEY_W-1:IDX_W]} + (TIME_W + 1)'(task_duration);
  assign fin_sat = fin_sum[TIME_W] ? {TIME_W{1'b1}} : fin_sum[TIME_W-1:0];

  // heap write: moved-up child or the sifted entry
  assign wr_key = cmd.swap ? best_key : item_key;
  assign wr_en  = (cmd.swap || cmd.place) && (pos != '0);

  // worker count clamp
  always_comb begin
    cfg_val = 32'(cfg_data);
    if (cfg_val == 32'd0) begin
      cfg_val = 32'd1;
    end else if (cfg_val > 32'(MAXW)) begin
      cfg_val = 32'(MAXW);
    end
    count_next = CNT_W'(cfg_val);
  end

  // heap memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[pos] <= wr_key;
    end
    if (cmd.fetch) begin
      rd_l_key  <= mem_key[left_idx[IDX_W-1:0]];
      rd_r_key  <= mem_key[right_idx[IDX_W-1:0]];
      rd_l_ok   <= mem_ok[left_idx[IDX_W-1:0]];
      rd_r_ok   <= mem_ok[right_idx[IDX_W-1:0]];
      rd_l_addr <= left_idx[IDX_W-1:0];
      rd_r_addr <= right_idx[IDX_W-1:0];
      r_in_use  <= right_idx < CHILD_W'(count);
    end
  end

  // valid bits, cleared on reset and on a new worker count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mem_ok <= '0;
    end else if (wr_en) begin
      mem_ok[pos] <= 1'b1;
    end
  end

  // root, sift state and worker count
  always_ff @(posedge clk) begin
    if (rst) begin
      root_key <= '0;
      pos      <= '0;
      count    <= CNT_W'(1);
    end else begin
      if (cmd.clear) begin
        root_key <= '0;
        pos      <= '0;
        count    <= count_next;
      end
      if (cmd.load) begin
        pos <= '0;
      end
      if (cmd.swap) begin
        pos <= best_idx[IDX_W-1:0];
      end
      if ((cmd.swap || cmd.place) && (pos == '0)) begin
        root_key <= wr_key;
      end
    end
  end

  // entry being sifted down
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_key <= {fin_sat, root_key[IDX_W-1:0]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      worker_index <= efws_pkg::WIDX_W'(root_key[IDX_W-1:0]);
      task_start   <= root_key[KEY_W-1:IDX_W];
    end
  end

  // sifting always descends
  a_pos_descends: assert property (@(posedge clk) disable iff (rst)
    cmd.swap |=> pos > $past(pos))
    else $error("sift position did not move down");

  // sift position stays within the workers in use
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    CHILD_W'(pos) < CHILD_W'(count))
    else $error("sift position beyond worker count");

  // an accepted task always yields a pending result
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_tvalid)
    else $error("no result after input beat");

  // finish time never falls below the start time
  a_fin_not_before: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> item_key[KEY_W-1:IDX_W] >= task_start)
    else $error("finish time before start time");

endmodule
